// ----- design/spcc_pkg.sv -----
// shared constants and opcodes for the segment point coverage counter
`default_nettype none

package spcc_pkg;

    // default sizing of the segment store and coordinates
    localparam int MAX_SEGMENTS_DEF = 1024;
    localparam int COORD_WIDTH_DEF  = 32;

    // width of the input coordinate ports and of the result port
    localparam int PORT_COORD_W = 32;
    localparam int COUNT_W      = 12;

    // operation codes carried on op
    typedef enum logic
    {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

endpackage : spcc_pkg

`default_nettype wire

// ----- design/spcc_cell.sv -----
// one slot of the segment store plus one stage of the query pipeline
`default_nettype none

module spcc_cell #(
    parameter int IDX     = 0,
    parameter int CW      = 32,
    parameter int CNT_W   = 11,
    parameter int SUM_W   = 12
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    advance,
    // segment write, broadcast to every cell
    input  wire logic                    wr_en,
    input  wire logic        [CNT_W-1:0] wr_slot,
    input  wire logic signed [CW-1:0]    wr_start,
    input  wire logic signed [CW-1:0]    wr_end,
    // query coming from the previous cell
    input  wire logic                    in_valid,
    input  wire logic signed [CW-1:0]    in_point,
    input  wire logic        [CNT_W-1:0] in_limit,
    input  wire logic        [SUM_W-1:0] in_sum,
    // query going to the next cell
    output logic                         out_valid,
    output logic signed      [CW-1:0]    out_point,
    output logic             [CNT_W-1:0] out_limit,
    output logic             [SUM_W-1:0] out_sum
);
    import spcc_pkg::*;

    localparam logic [CNT_W-1:0] MY_SLOT = CNT_W'(IDX);

    logic signed [CW-1:0]    start_reg;
    logic signed [CW-1:0]    end_reg;
    logic                    valid_reg;
    logic signed [CW-1:0]    point_reg;
    logic        [CNT_W-1:0] limit_reg;
    logic        [SUM_W-1:0] sum_reg;
    logic        [SUM_W-1:0] sum_next;
    logic                    in_use;
    logic                    start_hit;
    logic                    end_hit;

    // stored segment, written once when its slot comes up
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_slot == MY_SLOT))
        begin
            start_reg <= wr_start;
            end_reg   <= wr_end;
        end
    end

    // this slot counts only if it was filled when the query came in
    always_comb
    begin
        in_use    = MY_SLOT < in_limit;
        start_hit = in_use && (start_reg <= in_point);
        end_hit   = in_use && (end_reg < in_point);
        sum_next  = in_sum + SUM_W'(start_hit) - SUM_W'(end_hit);
    end

    // query stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // query stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            point_reg <= in_point;
            limit_reg <= in_limit;
            sum_reg   <= sum_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_point = point_reg;
    assign out_limit = limit_reg;
    assign out_sum   = sum_reg;

endmodule : spcc_cell

`default_nettype wire

// ----- design/segment_point_coverage_count.sv -----
// top level: segment store as a chain of compare cells with a query pipeline
// The block holds up to MAX_SEGMENTS segments, one per cell of a chain. An add
// request writes the next free cell and gives no result; adds past capacity are
// dropped. A query request enters the chain and moves one cell per cycle, each
// cell adding one for a start at or below the point and taking one away for an
// end strictly below it; cells filled after the query entered are not counted.
// One request is taken every cycle, adds and queries mixed freely. A query's
// result passes through the cell stages and then the output register, the
// first stage loading on the edge that takes it. The whole chain holds while
// a result waits at the output. The count saturates to the 12-bit signed
// range.
`default_nettype none

module segment_point_coverage_count #(
    parameter int MAX_SEGMENTS = spcc_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_WIDTH  = spcc_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     in_valid,
    output logic                                          in_ready,
    input  wire logic                                     op,
    input  wire logic signed [spcc_pkg::PORT_COORD_W-1:0] seg_start,
    input  wire logic signed [spcc_pkg::PORT_COORD_W-1:0] seg_end,
    input  wire logic signed [spcc_pkg::PORT_COORD_W-1:0] query_point,
    output logic                                          out_valid,
    input  wire logic                                     out_ready,
    output logic signed      [spcc_pkg::COUNT_W-1:0]      covered_count
);
    import spcc_pkg::*;

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int EXT_W = (SUM_W > COUNT_W) ? SUM_W : COUNT_W;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_SEGMENTS);
    localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'((1 << (COUNT_W - 1)) - 1);
    localparam logic signed [EXT_W-1:0] SAT_MIN = -EXT_W'(1 << (COUNT_W - 1));

    logic                    advance;
    logic                    accept;
    logic                    wr_en;
    logic                    q_enter;
    logic        [CNT_W-1:0] total_reg;
    logic        [CNT_W-1:0] total_next;
    logic signed [COORD_WIDTH-1:0] start_c;
    logic signed [COORD_WIDTH-1:0] end_c;
    logic signed [COORD_WIDTH-1:0] point_c;

    logic                          out_valid_reg;
    logic signed [COUNT_W-1:0]     covered_count_reg;
    logic signed [COUNT_W-1:0]     covered_count_next;
    logic signed [EXT_W-1:0]       final_ext;

    // chain links, one more than cells
    logic                          link_valid [MAX_SEGMENTS+1];
    logic signed [COORD_WIDTH-1:0] link_point [MAX_SEGMENTS+1];
    logic        [CNT_W-1:0]       link_limit [MAX_SEGMENTS+1];
    logic        [SUM_W-1:0]       link_sum   [MAX_SEGMENTS+1];

    // handshake: the chain moves unless a result is stuck at the output
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && in_ready;
    assign wr_en    = accept && (op_t'(op) == OP_ADD) && (total_reg < FULL);
    assign q_enter  = accept && (op_t'(op) == OP_QUERY);

    // coordinates taken at the configured width, port bits zero-extended
    assign start_c = COORD_WIDTH'($unsigned(seg_start));
    assign end_c   = COORD_WIDTH'($unsigned(seg_end));
    assign point_c = COORD_WIDTH'($unsigned(query_point));

    // fill count of the store
    always_comb
    begin
        total_next = total_reg;
        if (wr_en)
        begin
            total_next = total_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else
        begin
            total_reg <= total_next;
        end
    end

    // head of the chain
    assign link_valid[0] = q_enter;
    assign link_point[0] = point_c;
    assign link_limit[0] = total_reg;
    assign link_sum[0]   = '0;

    // row of cells
    for (genvar i = 0; i < MAX_SEGMENTS; i++)
    begin : g_cell
        spcc_cell #(
            .IDX   (i),
            .CW    (COORD_WIDTH),
            .CNT_W (CNT_W),
            .SUM_W (SUM_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .wr_en     (wr_en),
            .wr_slot   (total_reg),
            .wr_start  (start_c),
            .wr_end    (end_c),
            .in_valid  (link_valid[i]),
            .in_point  (link_point[i]),
            .in_limit  (link_limit[i]),
            .in_sum    (link_sum[i]),
            .out_valid (link_valid[i+1]),
            .out_point (link_point[i+1]),
            .out_limit (link_limit[i+1]),
            .out_sum   (link_sum[i+1])
        );
    end

    // saturate the final count to the result width
    always_comb
    begin
        final_ext = EXT_W'(signed'(link_sum[MAX_SEGMENTS]));
        if (final_ext > SAT_MAX)
        begin
            covered_count_next = COUNT_W'(SAT_MAX);
        end
        else if (final_ext < SAT_MIN)
        begin
            covered_count_next = COUNT_W'(SAT_MIN);
        end
        else
        begin
            covered_count_next = COUNT_W'(final_ext);
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= link_valid[MAX_SEGMENTS];
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            covered_count_reg <= covered_count_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign covered_count = covered_count_reg;

endmodule : segment_point_coverage_count

`default_nettype wire

// ----- test/segment_point_coverage_count_tb.sv -----
// testbench for the segment point coverage counter: directed and random runs
`timescale 1ns / 100ps

module segment_point_coverage_count_tb;

    import spcc_pkg::*;

    localparam int SEG_CAP     = MAX_SEGMENTS_DEF;
    localparam int CW          = PORT_COORD_W;
    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_PCT    = 14;

    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic                         op;
    logic signed [CW-1:0]         seg_start;
    logic signed [CW-1:0]         seg_end;
    logic signed [CW-1:0]         query_point;
    logic                         out_valid;
    logic                         out_ready;
    logic signed [COUNT_W-1:0]    covered_count;

    // local copy of the segment store
    logic signed [CW-1:0]         start_copy [SEG_CAP];
    logic signed [CW-1:0]         end_copy [SEG_CAP];
    int                           held_segments;

    // counts still owed by the block, oldest first
    logic signed [COUNT_W-1:0]    pending_counts [$];

    bit                           steady_flow;
    int                           cycle_count;
    int                           adds_taken;
    int                           adds_dropped;
    int                           queries_taken;
    int                           counts_checked;
    int                           mismatches;
    int                           stray_results;

    segment_point_coverage_count i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .seg_start     (seg_start),
        .seg_end       (seg_end),
        .query_point   (query_point),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .covered_count (covered_count)
    );

    // clock
    always #10 clk = ~clk;

    // coverage count of a point over the held segments, saturated to the port width
    function automatic logic signed [COUNT_W-1:0] coverage_at(logic signed [CW-1:0] pt);
        int net;
        net = 0;
        for (int i = 0; i < held_segments; i++)
        begin
            if (start_copy[i] <= pt)
                net++;
            if (end_copy[i] < pt)
                net--;
        end
        if (net > 2047)
            net = 2047;
        if (net < -2048)
            net = -2048;
        return net[COUNT_W-1:0];
    endfunction

    // coordinate mix: mostly a dense cluster, some full range, some extremes
    function automatic logic signed [CW-1:0] pick_coord();
        logic signed [CW-1:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: v = COORD_MIN;
                    1: v = COORD_MAX;
                    2: v = '0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
            1, 2: v = $urandom;
            default: v = $signed($urandom_range(0, 200)) - 100;
        endcase
        return v;
    endfunction

    // present one request and wait for it to be taken, then update the prediction
    task automatic send_request(input op_t req_op, input logic signed [CW-1:0] s,
                                input logic signed [CW-1:0] e,
                                input logic signed [CW-1:0] p);
        if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= req_op;
        seg_start   <= s;
        seg_end     <= e;
        query_point <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (req_op == OP_ADD)
        begin
            if (held_segments < SEG_CAP)
            begin
                start_copy[held_segments] = s;
                end_copy[held_segments]   = e;
                held_segments++;
                adds_taken++;
            end
            else
                adds_dropped++;
        end
        else
        begin
            pending_counts.push_back(coverage_at(p));
            queries_taken++;
        end
    endtask

    task automatic add_segment(input logic signed [CW-1:0] s, input logic signed [CW-1:0] e);
        send_request(OP_ADD, s, e, $urandom);
    endtask

    task automatic ask_point(input logic signed [CW-1:0] p);
        send_request(OP_QUERY, $urandom, $urandom, p);
    endtask

    // random segment, well formed unless told otherwise
    task automatic add_random_segment(input bit inverted_ok);
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] t;
        a = pick_coord();
        b = pick_coord();
        if (!(inverted_ok && $urandom_range(0, 99) < 20) && a > b)
        begin
            t = a;
            a = b;
            b = t;
        end
        add_segment(a, b);
    endtask

    // queries on an empty store must all answer zero
    task automatic test_empty_store();
        ask_point(COORD_MIN);
        ask_point('0);
        ask_point(COORD_MAX);
    endtask

    // extreme, inverted and degenerate segments, queried at their boundaries
    task automatic test_boundaries();
        add_segment(COORD_MIN, COORD_MAX);
        add_segment(5, 10);
        add_segment(10, 5);
        add_segment(COORD_MAX, COORD_MAX);
        add_segment(COORD_MIN, COORD_MIN);
        add_segment(0, 0);
        ask_point(COORD_MIN);
        ask_point(COORD_MIN + 1);
        ask_point(4);
        ask_point(5);
        ask_point(10);
        ask_point(11);
        ask_point(0);
        ask_point(COORD_MAX - 1);
        ask_point(COORD_MAX);
    endtask

    // mixed adds and queries with random content, one stretch without idling
    task automatic test_random_mix();
        for (int n = 0; n < 630; n++)
        begin
            steady_flow = (n >= 250 && n < 400);
            if ($urandom_range(0, 99) < 50)
                add_random_segment(1'b1);
            else
                ask_point(pick_coord());
        end
        steady_flow = 1'b0;
    endtask

    // result check and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_counts.size() == 0)
            begin
                stray_results++;
                $display("unexpected result %0d with nothing pending", covered_count);
            end
            else
            begin
                if (covered_count !== pending_counts[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("covered_count mismatch: expected %0d, got %0d",
                                 pending_counts[0], covered_count);
                end
                void'(pending_counts.pop_front());
                counts_checked++;
            end
        end
        out_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = OP_ADD;
        seg_start     = '0;
        seg_end       = '0;
        query_point   = '0;
        out_ready     = 1'b0;
        steady_flow   = 1'b0;
        held_segments = 0;
        cycle_count   = 0;
        adds_taken     = 0;
        adds_dropped   = 0;
        queries_taken  = 0;
        counts_checked = 0;
        mismatches     = 0;
        stray_results  = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_store();
        test_boundaries();
        test_random_mix();

        // drain: every query answered, then room for the chain to settle
        in_valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (SEG_CAP + 16) @(posedge clk);

        $display("stored %0d segments, dropped %0d adds on a full store",
                 adds_taken, adds_dropped);
        $display("answered %0d of %0d point queries, %0d wrong, %0d unexpected",
                 counts_checked, queries_taken, mismatches, stray_results);
        if (mismatches == 0 && stray_results == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
